// File: design/cbis_pkg.sv
// cbis_pkg: shared constants, config register codes, channel payload types
// and the morton interleave helper for the circle body integrate step block
// no dependencies
package cbis_pkg;

  // number format and grid geometry
  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 10;
  localparam int CELL_W     = 21;

  // iterative unit depths
  localparam int SQ_STAGES  = 32;
  localparam int DIV_QB     = 34;
  localparam int DIV_DW     = 52;
  localparam int DIV_STAGES = DIV_QB + 1;

  // register reset values
  localparam logic [30:0] WORLD_RADIUS_RST = 31'd65536000;
  localparam logic [31:0] INV_CELL_RST     = 32'd6554;
  localparam logic [10:0] GRID_EDGE_RST    = 11'd200;

  // speed limit cap and the largest r^4 whose limit stays below it
  localparam logic [33:0] LIM_CAP = 34'h2_0000_0000;
  localparam logic [47:0] R4_MAX  = 48'd858993;

  // reciprocal of ten, exact for 32-bit operands with a shift of 35
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    CFG_WORLD_RADIUS = 2'd0,
    CFG_INV_CELL     = 2'd1,
    CFG_GRID_EDGE    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               valid_req;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [23:0]        body_radius;
    logic [20:0]        old_cell;
  } req_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [20:0]        cell_index;
    logic               moved;
  } rsp_t;

  // x bit i to bit 2i, y bit i to bit 2i+1, masked to the cell width
  function automatic logic [CELL_W-1:0] morton(input logic [COORD_BITS-1:0] x,
                                               input logic [COORD_BITS-1:0] y);
    logic [CELL_W-1:0] r;
    r = '0;
    for (int i = 0; i < COORD_BITS; i++) begin
      if (2 * i < CELL_W) r[2*i] = x[i];
      if (2 * i + 1 < CELL_W) r[2*i+1] = y[i];
    end
    return r;
  endfunction

endpackage

// File: design/cbis_req_if.sv
// cbis_req_if: input channel carrying one body record per transfer
// depends on cbis_pkg
interface cbis_req_if;
  logic          valid;
  logic          ready;
  cbis_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/cbis_rsp_if.sv
// cbis_rsp_if: output channel carrying one updated body per transfer
// depends on cbis_pkg
interface cbis_rsp_if;
  logic          valid;
  logic          ready;
  cbis_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/circle_body_integrate_step_top.sv
// circle_body_integrate_step_top: one-body-per-cycle integrator pipeline
// depends on cbis_pkg, cbis_req_if, cbis_rsp_if, cbis_isqrt, cbis_div
//
//   channel | dir | payload
//   req     | in  | body record: valid_req, position, velocity, radius, old cell
//   rsp     | out | new position, damped velocity, cell index, moved flag
//   cfg     | in  | write enable, register index, 32-bit data
//
// one item per cycle sustained while rsp takes results; the pipeline depth is set
// by two square root pipelines (32 stages each) and three divider pipelines
// (35 stages each) in series
// rst clears only the valid bits and the config registers
// a stall at rsp freezes the whole pipeline; req.ready is low while the output
// register holds a result that is not taken
module circle_body_integrate_step_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  cbis_req_if.sink           req,
  cbis_rsp_if.source         rsp
);

  localparam int NS = cbis_pkg::SQ_STAGES;
  localparam int ND = cbis_pkg::DIV_STAGES;
  localparam int QB = cbis_pkg::DIV_QB;
  localparam int DW = cbis_pkg::DIV_DW;
  localparam int CB = cbis_pkg::COORD_BITS;
  localparam int FB = cbis_pkg::FRAC_BITS;

  typedef struct packed {
    logic        pv;
    logic        live;
    logic [31:0] px0, py0, vx0, vy0;
    logic [23:0] rad;
    logic [20:0] old;
    logic [63:0] sqx, sqy;
    logic [47:0] r2raw;
    logic [31:0] r2;
    logic [63:0] s2;
    logic [47:0] r4;
    logic [39:0] r3;
    logic [33:0] lval;
    logic [49:0] dden;
    logic [63:0] ll, nx, ny;
    logic        lim_v;
    logic [31:0] vlx, vly;
    logic [31:0] mvx, mvy;
    logic [63:0] dmx, dmy;
    logic [31:0] npx, npy;
    logic [31:0] fvx, fvy;
    logic [30:0] lim;
    logic [31:0] mpx, mpy;
    logic [63:0] ppx, ppy;
    logic [61:0] limsq;
    logic [63:0] p2;
    logic        clamp;
    logic [63:0] nmx, nmy;
    logic [31:0] cpx, cpy;
    logic [31:0] csx, csy;
    logic        negx, negy;
    logic [63:0] prx, pry;
  } ctx_t;

  // config registers
  logic [30:0] world_radius;
  logic [31:0] inv_cell_size;
  logic [10:0] grid_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_radius  <= cbis_pkg::WORLD_RADIUS_RST;
      inv_cell_size <= cbis_pkg::INV_CELL_RST;
      grid_edge     <= cbis_pkg::GRID_EDGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cbis_pkg::CFG_WORLD_RADIUS: world_radius  <= cfg_data[30:0];
        cbis_pkg::CFG_INV_CELL:     inv_cell_size <= cfg_data;
        cbis_pkg::CFG_GRID_EDGE:    grid_edge     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // saturate a velocity-limit quotient to 32 bits signed
  function automatic logic [31:0] sat_mag(input logic neg, input logic [QB-1:0] q);
    if (!neg) return (q > QB'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    else return (q > QB'(32'h8000_0000)) ? 32'h8000_0000 : 32'd0 - q[31:0];
  endfunction

  // saturate a 35-bit two's complement value to 32 bits
  function automatic logic [31:0] sat35(input logic [34:0] v);
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) return v[31:0];
    else return v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  // global advance: pipeline moves when the output register can take a result
  logic en;
  logic ov;
  assign en        = !ov || rsp.ready;
  assign req.ready = en;

  ctx_t st1, st2, st3, st4, st5, st6, st7, st8, st9, st10, st11, st12, st13;
  ctx_t st1_next, st2_next, st3_next, st4_next, st5_next, st6_next, st7_next;
  ctx_t st8_next, st9_next, st10_next, st11_next, st12_next, st13_next;
  ctx_t dl_a [NS];
  ctx_t dl_b [ND];
  ctx_t dl_c [ND];
  ctx_t dl_d [NS];
  ctx_t dl_e [ND];

  logic [31:0]   root_a, root_d;
  logic [QB-1:0] quo_bx, quo_by, quo_cx, quo_cy, quo_ex, quo_ey;

  // stage 1: capture, velocity squares, radius square
  always_comb begin
    st1_next       = st1;
    st1_next.pv    = req.valid;
    st1_next.live  = req.data.valid_req;
    st1_next.px0   = req.data.pos_x;
    st1_next.py0   = req.data.pos_y;
    st1_next.vx0   = req.data.vel_x;
    st1_next.vy0   = req.data.vel_y;
    st1_next.rad   = req.data.body_radius;
    st1_next.old   = req.data.old_cell;
    st1_next.mvx   = mag32(req.data.vel_x);
    st1_next.mvy   = mag32(req.data.vel_y);
    st1_next.sqx   = 64'(st1_next.mvx) * 64'(st1_next.mvx);
    st1_next.sqy   = 64'(st1_next.mvy) * 64'(st1_next.mvy);
    st1_next.r2raw = 48'(req.data.body_radius) * 48'(req.data.body_radius);
  end

  // stage 2: r^2 and speed squared
  always_comb begin
    st2_next    = st1;
    st2_next.r2 = 32'(st1.r2raw >> FB);
    st2_next.s2 = st1.sqx + st1.sqy;
  end

  // stage 3: r^4 and r^3
  always_comb begin
    logic [63:0] prod4;
    logic [55:0] prod3;
    prod4       = 64'(st2.r2) * 64'(st2.r2);
    prod3       = 56'(st2.r2) * 56'(st2.rad);
    st3_next    = st2;
    st3_next.r4 = 48'(prod4 >> FB);
    st3_next.r3 = 40'(prod3 >> FB);
  end

  // stage 4: speed limit and displacement divisor
  always_comb begin
    st4_next      = st3;
    st4_next.lval = (st3.r4 > cbis_pkg::R4_MAX) ? cbis_pkg::LIM_CAP
                                                 : 34'(34'(st3.r4[19:0]) * 34'd10000);
    st4_next.dden = 50'(st3.r3) * 50'd1000;
  end

  // stage 5: limit squared and scale numerators
  always_comb begin
    st5_next    = st4;
    st5_next.ll = 64'(st4.lval[31:0]) * 64'(st4.lval[31:0]);
    st5_next.nx = 64'(st4.mvx) * 64'(st4.lval[31:0]);
    st5_next.ny = 64'(st4.mvy) * 64'(st4.lval[31:0]);
  end

  // stage 6: over-speed decision
  always_comb begin
    st6_next       = st5;
    st6_next.lim_v = (st5.lval[33:32] == 2'b00) && (st5.s2 > st5.ll);
  end

  // speed magnitude, then v*L/|v|
  cbis_isqrt u_sqrt_a (.clk(clk), .en(en), .din(st6.s2), .root(root_a));
  cbis_div u_div_bx (.clk(clk), .en(en), .num(dl_a[NS-1].nx), .den(DW'(root_a)),
                     .quo(quo_bx));
  cbis_div u_div_by (.clk(clk), .en(en), .num(dl_a[NS-1].ny), .den(DW'(root_a)),
                     .quo(quo_by));

  // stage 7: limited velocity
  always_comb begin
    st7_next     = dl_b[ND-1];
    st7_next.vlx = dl_b[ND-1].lim_v ? sat_mag(dl_b[ND-1].vx0[31], quo_bx) : dl_b[ND-1].vx0;
    st7_next.vly = dl_b[ND-1].lim_v ? sat_mag(dl_b[ND-1].vy0[31], quo_by) : dl_b[ND-1].vy0;
  end

  // stage 8: magnitudes for displacement and damping
  always_comb begin
    st8_next     = st7;
    st8_next.mvx = mag32(st7.vlx);
    st8_next.mvy = mag32(st7.vly);
    st8_next.dmx = 64'(st8_next.mvx + 32'd9) * 64'(cbis_pkg::RECIP10);
    st8_next.dmy = 64'(st8_next.mvy + 32'd9) * 64'(cbis_pkg::RECIP10);
  end

  // displacement |v|<<F / (1000*r^3)
  cbis_div u_div_cx (.clk(clk), .en(en), .num(64'(st8.mvx) << FB), .den(DW'(st8.dden)),
                     .quo(quo_cx));
  cbis_div u_div_cy (.clk(clk), .en(en), .num(64'(st8.mvy) << FB), .den(DW'(st8.dden)),
                     .quo(quo_cy));

  // stage 9: position sum, damping, circle limit
  always_comb begin
    logic [33:0] dmx_c, dmy_c;
    logic [34:0] ex, ey, sx, sy;
    logic [31:0] rx, ry;
    ctx_t c;
    c = dl_c[ND-1];
    // zero velocity does not move, zero r^3 moves by the cap
    if (c.mvx == 32'd0)       dmx_c = '0;
    else if (c.r3 == 40'd0)   dmx_c = 34'h1_0000_0000;
    else                      dmx_c = (quo_cx > 34'h1_0000_0000) ? 34'h1_0000_0000 : quo_cx;
    if (c.mvy == 32'd0)       dmy_c = '0;
    else if (c.r3 == 40'd0)   dmy_c = 34'h1_0000_0000;
    else                      dmy_c = (quo_cy > 34'h1_0000_0000) ? 34'h1_0000_0000 : quo_cy;
    ex = {{3{c.px0[31]}}, c.px0};
    ey = {{3{c.py0[31]}}, c.py0};
    sx = c.vlx[31] ? ex - {1'b0, dmx_c} : ex + {1'b0, dmx_c};
    sy = c.vly[31] ? ey - {1'b0, dmy_c} : ey + {1'b0, dmy_c};
    // 9/10 as m - ceil(m/10)
    rx = c.mvx - 32'(c.dmx[63:35]);
    ry = c.mvy - 32'(c.dmy[63:35]);
    st9_next     = c;
    st9_next.npx = sat35(sx);
    st9_next.npy = sat35(sy);
    st9_next.fvx = c.vlx[31] ? 32'd0 - rx : rx;
    st9_next.fvy = c.vly[31] ? 32'd0 - ry : ry;
    st9_next.lim = (world_radius >= 31'(c.rad)) ? world_radius - 31'(c.rad) : 31'd0;
  end

  // stage 10: position squares
  always_comb begin
    st10_next       = st9;
    st10_next.mpx   = mag32(st9.npx);
    st10_next.mpy   = mag32(st9.npy);
    st10_next.ppx   = 64'(st10_next.mpx) * 64'(st10_next.mpx);
    st10_next.ppy   = 64'(st10_next.mpy) * 64'(st10_next.mpy);
    st10_next.limsq = 62'(st9.lim) * 62'(st9.lim);
  end

  // stage 11: outside-circle decision and clamp numerators
  always_comb begin
    st11_next       = st10;
    st11_next.p2    = st10.ppx + st10.ppy;
    st11_next.clamp = st11_next.p2 > 64'(st10.limsq);
    st11_next.nmx   = 64'(st10.mpx) * 64'(st10.lim);
    st11_next.nmy   = 64'(st10.mpy) * 64'(st10.lim);
  end

  // radius of the position, then p*lim/|p|
  cbis_isqrt u_sqrt_d (.clk(clk), .en(en), .din(st11.p2), .root(root_d));
  cbis_div u_div_ex (.clk(clk), .en(en), .num(dl_d[NS-1].nmx), .den(DW'(root_d)),
                     .quo(quo_ex));
  cbis_div u_div_ey (.clk(clk), .en(en), .num(dl_d[NS-1].nmy), .den(DW'(root_d)),
                     .quo(quo_ey));

  // stage 12: clamped position and shift into world coordinates
  always_comb begin
    logic [33:0] wx, wy;
    ctx_t c;
    c = dl_e[ND-1];
    st12_next     = c;
    st12_next.cpx = c.clamp ? (c.npx[31] ? 32'd0 - quo_ex[31:0] : quo_ex[31:0]) : c.npx;
    st12_next.cpy = c.clamp ? (c.npy[31] ? 32'd0 - quo_ey[31:0] : quo_ey[31:0]) : c.npy;
    wx = {{2{st12_next.cpx[31]}}, st12_next.cpx} + {3'b000, world_radius};
    wy = {{2{st12_next.cpy[31]}}, st12_next.cpy} + {3'b000, world_radius};
    st12_next.negx = wx[33];
    st12_next.negy = wy[33];
    st12_next.csx  = wx[31:0];
    st12_next.csy  = wy[31:0];
  end

  // stage 13: scale into grid units
  always_comb begin
    st13_next     = st12;
    st13_next.prx = 64'(st12.csx) * 64'(inv_cell_size);
    st13_next.pry = 64'(st12.csy) * 64'(inv_cell_size);
  end

  // largest coordinate from grid_edge and the coordinate width
  logic [10:0]   ge_m1;
  logic [CB-1:0] emax;
  assign ge_m1 = (grid_edge == 11'd0) ? 11'd0 : grid_edge - 11'd1;
  assign emax  = (32'(ge_m1) > 32'((1 << CB) - 1)) ? CB'((1 << CB) - 1) : CB'(ge_m1);

  // output: coordinate clamp, morton index, pass-through of dead slots
  cbis_pkg::rsp_t rsp_next;
  always_comb begin
    logic [CB-1:0]              cx, cy;
    logic [cbis_pkg::CELL_W-1:0] cidx;
    if (st13.negx) cx = '0;
    else cx = (st13.prx[63:32] > 32'(emax)) ? emax : CB'(st13.prx[63:32]);
    if (st13.negy) cy = '0;
    else cy = (st13.pry[63:32] > 32'(emax)) ? emax : CB'(st13.pry[63:32]);
    cidx = cbis_pkg::morton(cx, cy);
    if (st13.live) begin
      rsp_next.new_pos_x  = st13.cpx;
      rsp_next.new_pos_y  = st13.cpy;
      rsp_next.new_vel_x  = st13.fvx;
      rsp_next.new_vel_y  = st13.fvy;
      rsp_next.cell_index = cidx;
      rsp_next.moved      = (cidx != st13.old);
    end else begin
      rsp_next.new_pos_x  = st13.px0;
      rsp_next.new_pos_y  = st13.py0;
      rsp_next.new_vel_x  = st13.vx0;
      rsp_next.new_vel_y  = st13.vy0;
      rsp_next.cell_index = st13.old;
      rsp_next.moved      = 1'b0;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st1.pv  <= 1'b0;
      st2.pv  <= 1'b0;
      st3.pv  <= 1'b0;
      st4.pv  <= 1'b0;
      st5.pv  <= 1'b0;
      st6.pv  <= 1'b0;
      st7.pv  <= 1'b0;
      st8.pv  <= 1'b0;
      st9.pv  <= 1'b0;
      st10.pv <= 1'b0;
      st11.pv <= 1'b0;
      st12.pv <= 1'b0;
      st13.pv <= 1'b0;
    end else if (en) begin
      st1  <= st1_next;
      st2  <= st2_next;
      st3  <= st3_next;
      st4  <= st4_next;
      st5  <= st5_next;
      st6  <= st6_next;
      st7  <= st7_next;
      st8  <= st8_next;
      st9  <= st9_next;
      st10 <= st10_next;
      st11 <= st11_next;
      st12 <= st12_next;
      st13 <= st13_next;
    end
  end

  // context lines alongside the square root and divider pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        dl_a[k].pv <= 1'b0;
        dl_d[k].pv <= 1'b0;
      end
      for (int k = 0; k < ND; k++) begin
        dl_b[k].pv <= 1'b0;
        dl_c[k].pv <= 1'b0;
        dl_e[k].pv <= 1'b0;
      end
    end else if (en) begin
      dl_a[0] <= st6;
      dl_b[0] <= dl_a[NS-1];
      dl_c[0] <= st8;
      dl_d[0] <= st11;
      dl_e[0] <= dl_d[NS-1];
      for (int k = 1; k < NS; k++) begin
        dl_a[k] <= dl_a[k-1];
        dl_d[k] <= dl_d[k-1];
      end
      for (int k = 1; k < ND; k++) begin
        dl_b[k] <= dl_b[k-1];
        dl_c[k] <= dl_c[k-1];
        dl_e[k] <= dl_e[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov       <= st13.pv;
      rsp.data <= rsp_next;
    end
  end

  assign rsp.valid = ov;

  // no result may appear right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid after reset");

  // a held result blocks new transfers in
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("input taken while output stalled");

  // a stall freezes the pipeline mid-way
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({st7.pv, st7.vlx, st7.vly, st12.pv, st12.cpx, st12.cpy}))
    else $error("pipeline moved during stall");

endmodule

// File: design/cbis_isqrt.sv
// cbis_isqrt: pipelined floor square root of a 64-bit value, one root bit
// per stage over SQ_STAGES stages; depends on cbis_pkg
module cbis_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] din,
  output logic [31:0] root
);

  localparam int NS = cbis_pkg::SQ_STAGES;

  logic [35:0] rem_q  [NS];
  logic [31:0] root_q [NS];
  logic [63:0] val_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [35:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] val_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = din;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
    end

    // bring down two bits, try root*4+1
    assign rem_sh = {rem_in[33:0], val_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[30:0], 1'b0};
        end
        val_q[k] <= {val_in[61:0], 2'b00};
      end
    end
  end

  assign root = root_q[NS-1];

endmodule

// File: design/cbis_div.sv
// cbis_div: pipelined restoring divider, 64-bit dividend, DIV_QB quotient
// bits saturated to all ones; DIV_STAGES stages; uses cbis_pkg
module cbis_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [63:0]                   num,
  input  logic [cbis_pkg::DIV_DW-1:0]   den,
  output logic [cbis_pkg::DIV_QB-1:0]   quo
);

  localparam int QB = cbis_pkg::DIV_QB;
  localparam int DW = cbis_pkg::DIV_DW;
  localparam int HW = 64 - QB;

  logic          sat_q [QB+1];
  logic [DW-1:0] rem_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] low_q [QB+1];
  logic [QB-1:0] q_q   [QB+1];

  // front stage: overflow check and split of the dividend
  always_ff @(posedge clk) begin
    if (en) begin
      sat_q[0] <= ({{(DW-HW){1'b0}}, num[63:QB]} >= den);
      rem_q[0] <= {{(DW-HW){1'b0}}, num[63:QB]};
      den_q[0] <= den;
      low_q[0] <= num[QB-1:0];
      q_q[0]   <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_st
    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        ge;

    assign rem_sh = {rem_q[k-1], low_q[k-1][QB-1]};
    assign diff   = rem_sh - {1'b0, den_q[k-1]};
    assign ge     = (rem_sh >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        sat_q[k] <= sat_q[k-1];
        den_q[k] <= den_q[k-1];
        low_q[k] <= {low_q[k-1][QB-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QB-2:0], ge};
      end
    end
  end

  assign quo = sat_q[QB] ? '1 : q_q[QB];

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for circle_body_integrate_step_top, with a
// body-update predictor, random stimulus, stalls on both channels and reg writes
// depends on cbis_pkg, cbis_req_if, cbis_rsp_if and the design top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbis_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 300;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cbis_req_if req ();
  cbis_rsp_if rsp ();

  circle_body_integrate_step_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the registers
  longint unsigned world_r = 64'd65536000;
  longint unsigned inv_cs = 64'd6554;
  longint unsigned grid_n = 64'd200;

  req_t pending_bodies[$];
  rsp_t expected_bodies[$];
  int errors = 0;
  int results_seen = 0;
  bit no_idle = 1'b0;
  bit hold_done = 1'b0;
  bit in_took = 1'b0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // c*num/den toward zero
  function automatic longint ratio(longint c, longint unsigned num, longint unsigned den);
    longint unsigned m;
    m = mag(c) * num / den;
    if (m > (64'd1 << 33)) m = 64'd1 << 33;
    return c < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint step_of(longint v, longint unsigned r3);
    longint unsigned m;
    if (v == 0) return 0;
    if (r3 == 0) m = 64'd1 << 32;
    else if (r3 > (64'd1 << 46)) m = 0;
    else begin
      m = (mag(v) << FRAC_BITS) / (64'd1000 * r3);
      if (m > (64'd1 << 32)) m = 64'd1 << 32;
    end
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned grid_coord(longint p, longint unsigned emax);
    longint s;
    longint unsigned c;
    s = p + longint'(world_r);
    if (s < 0) return 0;
    c = (longint'(s) * inv_cs) >> (2 * FRAC_BITS);
    return c > emax ? emax : c;
  endfunction

  // expected update of one body under the current registers
  function automatic rsp_t integrate_body(req_t b);
    longint px, py, vx, vy, lim;
    longint unsigned rad, r2, r3, r4, lmax, s2, p2, m, emax, cx, cy;
    logic [CELL_W-1:0] cidx;
    rsp_t o;
    px = longint'(b.pos_x);
    py = longint'(b.pos_y);
    vx = longint'(b.vel_x);
    vy = longint'(b.vel_y);
    if (!b.valid_req) begin
      o.new_pos_x = b.pos_x;
      o.new_pos_y = b.pos_y;
      o.new_vel_x = b.vel_x;
      o.new_vel_y = b.vel_y;
      o.cell_index = b.old_cell;
      o.moved = 1'b0;
      return o;
    end
    rad = 64'(b.body_radius);
    r2 = (rad * rad) >> FRAC_BITS;
    if (r2 > M32) r2 = M32;
    r4 = (r2 * r2) >> FRAC_BITS;
    r3 = (r2 * rad) >> FRAC_BITS;
    lmax = (r4 > 64'd858993) ? (64'd1 << 33) : 64'd10000 * r4;
    // speed limit
    s2 = mag(vx) * mag(vx) + mag(vy) * mag(vy);
    if (lmax < (64'd1 << 32) && s2 > lmax * lmax) begin
      m = root_floor(s2);
      vx = sat32(ratio(vx, lmax, m));
      vy = sat32(ratio(vy, lmax, m));
    end
    px = sat32(px + step_of(vx, r3));
    py = sat32(py + step_of(vy, r3));
    // pull back inside the world circle
    lim = longint'(world_r) - longint'(rad);
    if (lim < 0) lim = 0;
    p2 = mag(px) * mag(px) + mag(py) * mag(py);
    if (p2 > longint'(lim) * longint'(lim)) begin
      m = root_floor(p2);
      px = ratio(px, longint'(lim), m);
      py = ratio(py, longint'(lim), m);
    end
    // grid cell, interleaved
    emax = grid_n == 0 ? 0 : grid_n - 1;
    if (emax > (64'd1 << COORD_BITS) - 1) emax = (64'd1 << COORD_BITS) - 1;
    cx = grid_coord(px, emax);
    cy = grid_coord(py, emax);
    cidx = '0;
    for (int i = 0; i < COORD_BITS; i++) begin
      if (2 * i < CELL_W) cidx[2*i] = cx[i];
      if (2 * i + 1 < CELL_W) cidx[2*i+1] = cy[i];
    end
    vx = ratio(vx, 9, 10);
    vy = ratio(vy, 9, 10);
    o.new_pos_x = px[31:0];
    o.new_pos_y = py[31:0];
    o.new_vel_x = vx[31:0];
    o.new_vel_y = vy[31:0];
    o.cell_index = cidx;
    o.moved = (cidx != b.old_cell);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch %s: got %h, want %h", what, got, want);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WORLD_RADIUS: world_r = 64'(val & 32'h7FFF_FFFF);
      CFG_INV_CELL: inv_cs = 64'(val);
      CFG_GRID_EDGE: grid_n = 64'(val & 32'h7FF);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic req_t body_item(logic vreq, logic [31:0] px, logic [31:0] py,
                                     logic [31:0] vx, logic [31:0] vy,
                                     logic [23:0] rad, logic [20:0] old);
    req_t b;
    b.valid_req = vreq;
    b.pos_x = px;
    b.pos_y = py;
    b.vel_x = vx;
    b.vel_y = vy;
    b.body_radius = rad;
    b.old_cell = old;
    return b;
  endfunction

  // mostly plausible bodies, some raw noise
  function automatic req_t random_body();
    req_t b;
    rsp_t p;
    if ($urandom_range(0, 99) < 30) begin
      b = body_item(1'($urandom), $urandom, $urandom, $urandom, $urandom,
                    24'($urandom), 21'($urandom));
      if (b.body_radius == 0) b.body_radius = 24'd1;
    end else begin
      b.valid_req = ($urandom_range(0, 9) != 0);
      b.pos_x = $signed($urandom) >>> $urandom_range(0, 12);
      b.pos_y = $signed($urandom) >>> $urandom_range(0, 12);
      b.vel_x = $signed($urandom) >>> $urandom_range(2, 26);
      b.vel_y = $signed($urandom) >>> $urandom_range(2, 26);
      b.body_radius = 24'($urandom_range(24'h2000, 24'h60000));
      b.old_cell = 21'($urandom_range(0, 1048576));
      p = integrate_body(b);
      if ($urandom_range(0, 1)) b.old_cell = p.cell_index;
    end
    return b;
  endfunction

  task automatic wait_drained();
    while (pending_bodies.size() != 0 || req.valid || expected_bodies.size() != 0)
      @(negedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_bodies.push_back(random_body());
    wait_drained();
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst && (!req.valid || in_took)) begin
      if (pending_bodies.size() != 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
        req.data <= pending_bodies.pop_front();
        req.valid <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off
  int hold_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && results_seen >= 500) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= no_idle || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // monitor: predict on input transfer, check on output transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    rsp_t want;
    in_took <= req.valid && req.ready;
    if (!rst) begin
      if (req.valid && req.ready) expected_bodies.push_back(integrate_body(req.data));
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_bodies.size() == 0) begin
          report_mismatch("unexpected result", 64'(rsp.data.cell_index), 64'd0);
        end else begin
          want = expected_bodies.pop_front();
          if (rsp.data.new_pos_x != want.new_pos_x)
            report_mismatch("new_pos_x", 64'(unsigned'(rsp.data.new_pos_x)),
                            64'(unsigned'(want.new_pos_x)));
          if (rsp.data.new_pos_y != want.new_pos_y)
            report_mismatch("new_pos_y", 64'(unsigned'(rsp.data.new_pos_y)),
                            64'(unsigned'(want.new_pos_y)));
          if (rsp.data.new_vel_x != want.new_vel_x)
            report_mismatch("new_vel_x", 64'(unsigned'(rsp.data.new_vel_x)),
                            64'(unsigned'(want.new_vel_x)));
          if (rsp.data.new_vel_y != want.new_vel_y)
            report_mismatch("new_vel_y", 64'(unsigned'(rsp.data.new_vel_y)),
                            64'(unsigned'(want.new_vel_y)));
          if (rsp.data.cell_index != want.cell_index)
            report_mismatch("cell_index", 64'(rsp.data.cell_index), 64'(want.cell_index));
          if (rsp.data.moved != want.moved)
            report_mismatch("moved", 64'(rsp.data.moved), 64'(want.moved));
        end
      end
    end
    // watchdog on transfer inactivity
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("circle_body_integrate_step_top regression: fail");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed bodies under reset settings
    pending_bodies.push_back(body_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 24'hFF_FFFF, 21'h1F_FFFF));
    pending_bodies.push_back(body_item(1'b0, 0, 0, 0, 0, 24'd1, 21'd0));
    pending_bodies.push_back(body_item(1'b1, 0, 0, 0, 0, 24'h1_0000, 21'd0));
    pending_bodies.push_back(body_item(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 24'h1_0000, 21'd1048576));
    pending_bodies.push_back(body_item(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 24'h1_0000, 21'd0));
    // radius so small that r^3 is zero
    pending_bodies.push_back(body_item(1'b1, 32'h0010_0000, 32'hFFF0_0000, 32'd5,
                                       32'hFFFF_FFFB, 24'd1, 21'd3));
    pending_bodies.push_back(body_item(1'b1, 32'h0010_0000, 0, 0, 32'h0001_0000,
                                       24'd1, 21'd3));
    // zero speed limit with nonzero r^3
    pending_bodies.push_back(body_item(1'b1, 32'h0100_0000, 32'h0100_0000, 32'h0040_0000,
                                       32'hFFC0_0000, 24'd4000, 21'd7));
    // largest radius
    pending_bodies.push_back(body_item(1'b1, 32'h0200_0000, 32'hFE00_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 24'hFF_FFFF, 21'd0));
    // limit engaged with a mid radius
    pending_bodies.push_back(body_item(1'b1, 0, 0, 32'h4000_0000, 32'h3000_0000,
                                       24'h0_4000, 21'd100));
    // outside the world circle
    pending_bodies.push_back(body_item(1'b1, 32'h3E80_0000, 32'h3E80_0000, 0, 0,
                                       24'h2_0000, 21'd0));
    pending_bodies.push_back(body_item(1'b1, 32'hC000_0000, 32'h0000_0001, 32'h0001_0000,
                                       0, 24'h1_0000, 21'h1F_FFFF));
    pending_bodies.push_back(body_item(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'h0000_0001, 24'h8000, 21'd0));
    wait_drained();

    // defaults rewritten, no idling on either side
    write_reg(CFG_WORLD_RADIUS, 32'd65536000);
    write_reg(CFG_INV_CELL, 32'd6554);
    write_reg(CFG_GRID_EDGE, 32'd200);
    no_idle = 1'b1;
    random_phase(PHASE_ITEMS);
    no_idle = 1'b0;

    // upper extremes; the long output hold-off falls here
    write_reg(CFG_WORLD_RADIUS, 32'h7FFF_FFFF);
    write_reg(CFG_INV_CELL, 32'hFFFF_FFFF);
    write_reg(CFG_GRID_EDGE, 32'd1024);
    random_phase(PHASE_ITEMS);

    // lower extremes
    write_reg(CFG_WORLD_RADIUS, 32'd65536);
    write_reg(CFG_INV_CELL, 32'd1);
    write_reg(CFG_GRID_EDGE, 32'd1);
    random_phase(PHASE_ITEMS);

    // zero grid edge, spare index ignored
    write_reg(CFG_WORLD_RADIUS, $urandom_range(65536, 32'h7FFF_FFFF));
    write_reg(CFG_INV_CELL, $urandom);
    write_reg(CFG_GRID_EDGE, 32'd0);
    write_reg(CFG_SPARE, $urandom);
    random_phase(PHASE_ITEMS);

    // world smaller than the bodies, oversized grid edge
    write_reg(CFG_WORLD_RADIUS, 32'd1000);
    write_reg(CFG_INV_CELL, 32'd65536);
    write_reg(CFG_GRID_EDGE, 32'd2047);
    random_phase(PHASE_ITEMS);

    // random plausible settings
    write_reg(CFG_WORLD_RADIUS, $urandom_range(32'h0100_0000, 32'h7FFF_FFFF));
    write_reg(CFG_INV_CELL, $urandom_range(1000, 400000));
    write_reg(CFG_GRID_EDGE, $urandom_range(1, 1024));
    random_phase(PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_bodies.size() == 0) begin
      $display("circle_body_integrate_step_top regression: pass");
    end else begin
      $display("circle_body_integrate_step_top regression: fail");
    end
    $finish;
  end

endmodule
